// ===== src/mdr_pkg.sv =====
// shared types, codes and fixed-point helpers for the meter dial digit resolver
package mdr_pkg;

  localparam int unsigned ReadingW = 10;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned ClassW   = 4;
  localparam int unsigned KindW    = 2;

  // dial kind codes
  localparam logic [KindW-1:0] KindAnalog  = 2'd0;
  localparam logic [KindW-1:0] KindDigital = 2'd1;
  localparam logic [KindW-1:0] KindHybrid  = 2'd2;

  // configuration register indexes
  localparam logic CfgDialKind = 1'b0;
  localparam logic CfgExtRes   = 1'b1;

  // carry thresholds in hundredths
  localparam logic [ReadingW-1:0] CarryLow  = 10'd920;
  localparam logic [ReadingW-1:0] CarryHigh = 10'd950;
  localparam logic [ClassW-1:0]   ClassMax  = 4'd9;

  typedef struct packed {
    logic [ReadingW-1:0] reading;
    logic                reading_valid;
    logic [ClassW-1:0]   digit_class;
    logic                first_in_number;
  } mdr_item_t;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              digit_known;
    logic [DigitW-1:0] tenths_digit;
    logic              tenths_present;
    logic              tenths_known;
  } mdr_result_t;

  typedef struct packed {
    logic [DigitW-1:0]   digit;
    logic                digit_known;
    logic [ReadingW-1:0] reading;
    logic                reading_known;
  } mdr_hist_t;

  // x / 100 for x up to 1073, by reciprocal multiply
  function automatic logic [DigitW-1:0] div100(input logic [ReadingW:0] x);
    logic [16:0] p;
    p = {6'd0, x} * 17'd41;
    return p[15:12];
  endfunction

  // fold a quotient of 0..10 back into one decimal digit
  function automatic logic [DigitW-1:0] mod10(input logic [DigitW-1:0] x);
    return (x >= 4'd10) ? x - 4'd10 : x;
  endfunction

  // tenths of r given its whole hundreds q
  function automatic logic [DigitW-1:0] tenths_of(input logic [ReadingW-1:0] r,
                                                   input logic [DigitW-1:0]   q);
    logic [10:0] hq;
    logic [10:0] rem;
    logic [14:0] p;
    hq  = {7'd0, q} * 11'd100;
    rem = {1'b0, r} - hq;
    p   = {8'd0, rem[6:0]} * 15'd205;
    return p[14:11];
  endfunction

endpackage

// ===== src/mdr_resolve.sv =====
// combinational digit resolution of one dial against the previous dial
module mdr_resolve
  import mdr_pkg::*;
(
  input  logic [KindW-1:0] cfg_kind_i,
  input  logic             cfg_ext_i,
  input  mdr_item_t        item_i,
  input  mdr_hist_t        hist_i,
  output mdr_result_t      result_o,
  output logic             hist_we_o,
  output mdr_hist_t        hist_o
);

  logic [DigitW-1:0] fl_q, rd_q, flr, rnd, tnt, band, analog, hybrid;
  logic              dec;
  logic              rec_valid;

  assign fl_q = div100({1'b0, item_i.reading});
  assign rd_q = div100({1'b0, item_i.reading} + 11'd50);
  assign flr  = mod10(fl_q);
  assign rnd  = mod10(rd_q);
  assign tnt  = tenths_of(item_i.reading, fl_q);
  assign band = (tnt <= 4'd2 || tnt >= 4'd8) ? rnd : flr;

  // pull back by one when the tenths lag the previous digit
  always_comb begin
    if (tnt >= 4'd5) begin
      dec = ({1'b0, tnt} < ({1'b0, hist_i.digit} + 5'd5));
    end else begin
      dec = (({1'b0, tnt} + 5'd5) < {1'b0, hist_i.digit});
    end
    if (!dec) begin
      analog = rnd;
    end else if (rd_q == '0) begin
      analog = 4'd9;
    end else begin
      analog = rd_q - 4'd1;
    end
  end

  always_comb begin
    if (!hist_i.reading_known || hist_i.reading <= CarryLow) begin
      hybrid = band;
    end else if (hist_i.digit_known && hist_i.digit == '0) begin
      hybrid = rnd;
    end else if (hist_i.reading <= CarryHigh) begin
      hybrid = band;
    end else begin
      hybrid = flr;
    end
  end

  always_comb begin
    result_o  = '0;
    hist_we_o = 1'b1;
    rec_valid = 1'b1;
    unique case (cfg_kind_i)
      KindAnalog: begin
        result_o.digit_known = 1'b1;
        if (item_i.first_in_number || !hist_i.digit_known) begin
          result_o.digit = flr;
          if (item_i.first_in_number && cfg_ext_i) begin
            result_o.tenths_present = 1'b1;
            result_o.tenths_known   = 1'b1;
            result_o.tenths_digit   = tnt;
          end
        end else begin
          result_o.digit = analog;
        end
      end
      KindDigital: begin
        if (item_i.digit_class <= ClassMax) begin
          result_o.digit       = item_i.digit_class;
          result_o.digit_known = 1'b1;
        end
      end
      KindHybrid: begin
        rec_valid = item_i.reading_valid;
        if (item_i.first_in_number) begin
          result_o.tenths_present = cfg_ext_i;
          if (item_i.reading_valid) begin
            result_o.digit_known = 1'b1;
            if (cfg_ext_i) begin
              result_o.digit        = flr;
              result_o.tenths_digit = tnt;
              result_o.tenths_known = 1'b1;
            end else begin
              result_o.digit = band;
            end
          end
        end else if (item_i.reading_valid) begin
          result_o.digit_known = 1'b1;
          result_o.digit       = hybrid;
        end
      end
      default: begin
        hist_we_o = 1'b0;
      end
    endcase
  end

  assign hist_o.digit         = result_o.digit;
  assign hist_o.digit_known   = result_o.digit_known;
  assign hist_o.reading       = item_i.reading;
  assign hist_o.reading_known = rec_valid;

endmodule

// ===== src/meter_dial_digit_resolver_unit.sv =====
// top level: input register, dial resolution, result register and dial history
// path: a dial passes the input register, then the result register, before its result is offered
// throughput: one dial per cycle unless stalled; the history of the previous dial is updated
//   in the same cycle its result is registered, so dials follow back to back
// reset: config registers, history and both valid flags clear at once;
//   no clearing pass, the block takes dials right after reset
module meter_dial_digit_resolver_unit
  import mdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [KindW-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ReadingW-1:0] reading_i,
  input  logic                reading_valid_i,
  input  logic [ClassW-1:0]   digit_class_i,
  input  logic                first_in_number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DigitW-1:0]   digit_o,
  output logic                digit_known_o,
  output logic [DigitW-1:0]   tenths_digit_o,
  output logic                tenths_present_o,
  output logic                tenths_known_o
);

  logic [KindW-1:0] kind_q;
  logic             ext_q;
  logic             item_vld_q, res_vld_q;
  mdr_item_t        item_q;
  mdr_result_t      res_q, res_d;
  mdr_hist_t        hist_q, hist_d;
  logic             hist_we;
  logic             res_ready, item_ready;

  assign res_ready  = !res_vld_q || !out_stall_i;
  assign item_ready = !item_vld_q || res_ready;
  assign in_stall_o = !item_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindAnalog;
      ext_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgDialKind: kind_q <= cfg_wdata_i;
        CfgExtRes:   ext_q  <= cfg_wdata_i[0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (item_ready) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready && in_valid_i) begin
      item_q.reading         <= reading_i;
      item_q.reading_valid   <= reading_valid_i;
      item_q.digit_class     <= digit_class_i;
      item_q.first_in_number <= first_in_number_i;
    end
  end

  mdr_resolve u_resolve (
    .cfg_kind_i (kind_q),
    .cfg_ext_i  (ext_q),
    .item_i     (item_q),
    .hist_i     (hist_q),
    .result_o   (res_d),
    .hist_we_o  (hist_we),
    .hist_o     (hist_d)
  );

  // history moves with the dial into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      hist_q    <= '0;
    end else if (res_ready) begin
      res_vld_q <= item_vld_q;
      if (item_vld_q && hist_we) begin
        hist_q <= hist_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && item_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_vld_q;
  assign digit_o          = res_q.digit;
  assign digit_known_o    = res_q.digit_known;
  assign tenths_digit_o   = res_q.tenths_digit;
  assign tenths_present_o = res_q.tenths_present;
  assign tenths_known_o   = res_q.tenths_known;

endmodule

// ===== src/mdr_checker.sv =====
// port-level checks on the resolver results, bound to the top level
module mdr_checker
  import mdr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DigitW-1:0] digit_o,
  input logic              digit_known_o,
  input logic [DigitW-1:0] tenths_digit_o,
  input logic              tenths_present_o,
  input logic              tenths_known_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(digit_o) && $stable(digit_known_o))
    else $error("stalled result changed");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !digit_known_o |-> digit_o == '0)
    else $error("unreadable digit not zero");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && digit_known_o |-> digit_o <= 4'd9)
    else $error("digit out of decimal range");

  a_tenths_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tenths_known_o |-> tenths_digit_o == '0)
    else $error("tenths digit given while unknown or absent");

endmodule

bind meter_dial_digit_resolver_unit mdr_checker u_mdr_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench for the meter dial digit resolver: directed dials, then random numbers
module testbench;
  import mdr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KindW-1:0] KindSpare = 2'd3;
  localparam int unsigned PhaseDials = 230;

  // tracks the dial history and configuration, and holds the digits still to come
  class digit_board;
    logic [KindW-1:0] kind;
    logic             ext;
    mdr_hist_t        prev;
    mdr_result_t      awaited [$];
    int unsigned      faults;

    function new();
      kind   = KindAnalog;
      ext    = 1'b0;
      prev   = '0;
      faults = 0;
    endfunction

    function void set_reg(logic idx, logic [KindW-1:0] val);
      if (idx == CfgDialKind) begin
        kind = val;
      end else begin
        ext = val[0];
      end
    endfunction

    function int tenth_of(int unsigned r);
      return (r / 10) % 10;
    endfunction

    function int whole_of(int unsigned r);
      return (r / 100) % 10;
    endfunction

    function int nearest_of(int unsigned r);
      return ((r + 50) / 100) % 10;
    endfunction

    // round near whole digits, floor in the middle of the dial
    function int banded(int unsigned r);
      int t;
      t = tenth_of(r);
      if (t <= 2 || t >= 8) begin
        return nearest_of(r);
      end
      return whole_of(r);
    endfunction

    // rounded position, one less when the tenths lag the lower dial
    function int pulled_back(int unsigned r, int lower);
      int t;
      int rating;
      int res;
      t      = tenth_of(r);
      rating = t - lower;
      if (t >= 5) begin
        rating -= 5;
      end else begin
        rating += 5;
      end
      res = (r + 50) / 100;
      if (rating < 0) begin
        res -= 1;
      end
      return (res + 10) % 10;
    endfunction

    function int carried(int unsigned r);
      if (!prev.reading_known || prev.reading <= CarryLow) begin
        return banded(r);
      end
      if (prev.digit_known && prev.digit == '0) begin
        return nearest_of(r);
      end
      if (prev.reading <= CarryHigh) begin
        return banded(r);
      end
      return whole_of(r);
    endfunction

    function mdr_result_t resolve_dial(mdr_item_t d);
      mdr_result_t res;
      logic        keep_hist;
      logic        rec_known;
      res       = '0;
      keep_hist = 1'b1;
      rec_known = 1'b1;
      case (kind)
        KindAnalog: begin
          res.digit_known = 1'b1;
          if (d.first_in_number || !prev.digit_known) begin
            res.digit = DigitW'(whole_of(d.reading));
            if (d.first_in_number && ext) begin
              res.tenths_present = 1'b1;
              res.tenths_known   = 1'b1;
              res.tenths_digit   = DigitW'(tenth_of(d.reading));
            end
          end else begin
            res.digit = DigitW'(pulled_back(d.reading, int'(prev.digit)));
          end
        end
        KindDigital: begin
          if (d.digit_class <= ClassMax) begin
            res.digit       = d.digit_class;
            res.digit_known = 1'b1;
          end
        end
        KindHybrid: begin
          rec_known = d.reading_valid;
          if (d.first_in_number) begin
            res.tenths_present = ext;
            if (d.reading_valid) begin
              res.digit_known = 1'b1;
              if (ext) begin
                res.digit        = DigitW'(whole_of(d.reading));
                res.tenths_digit = DigitW'(tenth_of(d.reading));
                res.tenths_known = 1'b1;
              end else begin
                res.digit = DigitW'(banded(d.reading));
              end
            end
          end else if (d.reading_valid) begin
            res.digit_known = 1'b1;
            res.digit       = DigitW'(carried(d.reading));
          end
        end
        default: begin
          keep_hist = 1'b0;
        end
      endcase
      if (keep_hist) begin
        prev.digit         = res.digit;
        prev.digit_known   = res.digit_known;
        prev.reading       = d.reading;
        prev.reading_known = rec_known;
      end
      return res;
    endfunction

    function void take_dial(mdr_item_t d);
      awaited.insert(awaited.size(), resolve_dial(d));
    endfunction

    function void flag(string what, int unsigned want, int unsigned seen);
      $display("%0t: %s expected %0d got %0d", $time, what, want, seen);
      faults++;
    endfunction

    function void match_digit(mdr_result_t got);
      mdr_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, got digit %0d known %0b",
                 $time, got.digit, got.digit_known);
        faults++;
        return;
      end
      want = awaited.pop_front();
      if (got.digit !== want.digit) flag("digit", want.digit, got.digit);
      if (got.digit_known !== want.digit_known)
        flag("digit_known", want.digit_known, got.digit_known);
      if (got.tenths_digit !== want.tenths_digit)
        flag("tenths_digit", want.tenths_digit, got.tenths_digit);
      if (got.tenths_present !== want.tenths_present)
        flag("tenths_present", want.tenths_present, got.tenths_present);
      if (got.tenths_known !== want.tenths_known)
        flag("tenths_known", want.tenths_known, got.tenths_known);
    endfunction
  endclass

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                cfg_we_i          = 1'b0;
  logic                cfg_addr_i        = 1'b0;
  logic [KindW-1:0]    cfg_wdata_i       = '0;
  logic                in_valid_i        = 1'b0;
  logic                in_stall_o;
  logic [ReadingW-1:0] reading_i         = '0;
  logic                reading_valid_i   = 1'b0;
  logic [ClassW-1:0]   digit_class_i     = '0;
  logic                first_in_number_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i       = 1'b0;
  logic [DigitW-1:0]   digit_o;
  logic                digit_known_o;
  logic [DigitW-1:0]   tenths_digit_o;
  logic                tenths_present_o;
  logic                tenths_known_o;

  digit_board board;
  int         gap_pct    = 0;
  int         stall_pct  = 0;
  int         dials_left = 0;
  logic       noisy      = 1'b0;

  logic [KindW-1:0] plan_kind [8] = '{KindAnalog, KindAnalog, KindHybrid, KindHybrid,
                                      KindDigital, KindHybrid, KindSpare, KindAnalog};
  logic [KindW-1:0] plan_ext  [8] = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd3, 2'd1, 2'd1};

  meter_dial_digit_resolver_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .reading_i         (reading_i),
    .reading_valid_i   (reading_valid_i),
    .digit_class_i     (digit_class_i),
    .first_in_number_i (first_in_number_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .digit_o           (digit_o),
    .digit_known_o     (digit_known_o),
    .tenths_digit_o    (tenths_digit_o),
    .tenths_present_o  (tenths_present_o),
    .tenths_known_o    (tenths_known_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= roll(stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.match_digit({digit_o, digit_known_o, tenths_digit_o, tenths_present_o,
                         tenths_known_o});
    end
  end

  function automatic mdr_item_t make_dial(int unsigned r, logic v, int unsigned cls,
                                          logic first);
    mdr_item_t d;
    d.reading         = ReadingW'(r);
    d.reading_valid   = v;
    d.digit_class     = ClassW'(cls);
    d.first_in_number = first;
    return d;
  endfunction

  // mostly near whole digits, mid-dial and the carry thresholds
  function automatic logic [ReadingW-1:0] pick_reading();
    int unsigned h;
    h = 100 * $urandom_range(0, 9);
    case ($urandom_range(0, 4))
      0: return ReadingW'($urandom_range(0, 1023));
      1: return ReadingW'($urandom_range(880, 1023));
      2: return ReadingW'(h + $urandom_range(0, 29));
      3: return ReadingW'(h + $urandom_range(70, 99));
      default: return ReadingW'(h + $urandom_range(40, 60));
    endcase
  endfunction

  // dials of whole numbers; a few numbers get stray first flags and unknown readings
  function automatic mdr_item_t next_dial();
    mdr_item_t d;
    if (dials_left == 0) begin
      dials_left        = $urandom_range(1, 8);
      noisy             = roll(12);
      d.first_in_number = 1'b1;
    end else begin
      d.first_in_number = noisy ? roll(50) : 1'b0;
    end
    dials_left--;
    d.reading       = pick_reading();
    d.reading_valid = noisy ? roll(50) : roll(92);
    d.digit_class   = ClassW'($urandom_range(0, 15));
    return d;
  endfunction

  // entered and left just after a falling edge
  task automatic send_dial(input mdr_item_t d);
    while (roll(gap_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    reading_i         <= d.reading;
    reading_valid_i   <= d.reading_valid;
    digit_class_i     <= d.digit_class;
    first_in_number_i <= d.first_in_number;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_dial(d);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.awaited.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [KindW-1:0] val);
    board.set_reg(idx, val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    board = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config: analog, later dial with no lower dial yet
    send_dial(make_dial(537, 1'b1, 3, 1'b0));
    settle();
    write_reg(CfgExtRes, 2'd1);
    // reading_valid is ignored in analog mode
    send_dial(make_dial(0, 1'b0, 0, 1'b1));
    send_dial(make_dial(999, 1'b1, 15, 1'b1));
    send_dial(make_dial(999, 1'b1, 0, 1'b0));
    send_dial(make_dial(1023, 1'b1, 15, 1'b0));
    send_dial(make_dial(450, 1'b0, 7, 1'b0));
    settle();
    write_reg(CfgDialKind, KindDigital);
    send_dial(make_dial(0, 1'b1, 0, 1'b1));
    send_dial(make_dial(512, 1'b0, 9, 1'b0));
    send_dial(make_dial(300, 1'b1, 10, 1'b0));
    send_dial(make_dial(1023, 1'b1, 15, 1'b1));
    settle();
    write_reg(CfgDialKind, KindHybrid);
    // unknown first reading still brings an unknown fraction
    send_dial(make_dial(444, 1'b0, 0, 1'b1));
    send_dial(make_dial(500, 1'b1, 0, 1'b0));
    send_dial(make_dial(985, 1'b1, 0, 1'b1));
    send_dial(make_dial(760, 1'b1, 0, 1'b0));
    send_dial(make_dial(985, 1'b1, 0, 1'b0));
    // lower dial above 9.2 that resolved to zero
    send_dial(make_dial(380, 1'b1, 0, 1'b0));
    send_dial(make_dial(930, 1'b1, 0, 1'b0));
    send_dial(make_dial(250, 1'b1, 0, 1'b0));
    send_dial(make_dial(1010, 1'b1, 0, 1'b0));
    settle();
    write_reg(CfgExtRes, 2'd0);
    send_dial(make_dial(281, 1'b1, 0, 1'b1));
    settle();
    // spare kind leaves the history alone
    write_reg(CfgDialKind, KindSpare);
    send_dial(make_dial(620, 1'b1, 5, 1'b0));
    settle();
    write_reg(CfgDialKind, KindHybrid);
    send_dial(make_dial(130, 1'b1, 0, 1'b0));

    for (int p = 0; p < 8; p++) begin
      settle();
      write_reg(CfgDialKind, plan_kind[p]);
      write_reg(CfgExtRes, plan_ext[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 28; stall_pct = 28; end
      endcase
      // numbers run across phase boundaries, so modes change inside a number
      for (int n = 0; n < PhaseDials; n++) begin
        send_dial(next_dial());
      end
    end

    settle();
    repeat (4) @(negedge clk_i);
    if (board.faults == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("%0t: timeout, %0d transfers still awaited", $time, board.awaited.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
